/* hdl/ffba_pkg.sv */
// types and constants shared by the first-fit block allocator modules
// no dependencies
`default_nettype none

package ffba_pkg;

    localparam int ADDR_W   = 24;
    localparam int STATUS_W = 3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 3'd4;

    localparam logic [ADDR_W-1:0] ADDR_MAX = 24'hFF_FFFF;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] req_size;
        logic [ADDR_W-1:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } rsp_t;

    // one row of the block table
    typedef struct packed {
        logic              free;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] start;
    } entry_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

/* hdl/ffba_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/ffba_ctrl.sv */
// sequencer for the allocator: accept, walk the table, hand the result over
// depends on ffba_pkg
`default_nettype none

module ffba_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ffba_pkg::sts_t sts,
    output ffba_pkg::cmd_t     cmd
);
    import ffba_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && req_valid;
        cmd.step   = (state_reg == S_SCAN) && !sts.done;
        cmd.commit = (state_reg == S_SCAN) && sts.done && !sts.out_busy;
        req_stall  = (state_reg != S_IDLE);

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/ffba_dp.sv */
// datapath: request registers, table walk, heap bookkeeping, result register
// depends on ffba_pkg and ffba_ram
`default_nettype none

module ffba_dp #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24,
    parameter int HEAP_BASE    = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ffba_pkg::cmd_t            cmd,
    output ffba_pkg::sts_t                 sts,
    input  wire ffba_pkg::req_t            req,
    input  wire logic                      cfg_we,
    input  wire logic [ffba_pkg::ADDR_W-1:0] cfg_wdata,
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output ffba_pkg::rsp_t                 rsp
);
    import ffba_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0]       COUNT_MAX = CW'(MAX_BLOCKS);
    localparam logic [ADDR_W-1:0]   HDR       = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0]   BASE      = ADDR_W'(HEAP_BASE);

    // request captured at accept
    logic              mode_reg;
    logic [ADDR_W-1:0] want_reg;
    logic [ADDR_W:0]   target_reg;
    logic [ADDR_W:0]   need_reg;
    logic              ignored_reg;

    // heap bookkeeping
    logic [ADDR_W-1:0] limit_reg;
    logic [ADDR_W-1:0] heap_top_reg;
    logic [ADDR_W-1:0] used_reg;
    logic [CW-1:0]     count_reg;
    logic              grow_ok_reg;

    // table walk
    logic [CW-1:0]     rd_idx_reg;
    logic              cmp_valid_reg;
    logic [AW-1:0]     cmp_idx_reg;
    logic              first_reg;
    logic              found_reg;
    logic [AW-1:0]     found_idx_reg;
    entry_t            found_ent_reg;

    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    entry_t            ram_rdata;
    logic              match;
    logic              exhausted;
    logic [ADDR_W+1:0] used_sum;
    logic [ADDR_W+1:0] top_sum;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_ent;
    logic              append;
    rsp_t              res;

    ffba_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_ent),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (mode_reg == MODE_ALLOC)
        begin
            match = cmp_valid_reg && ram_rdata.free && (ram_rdata.size >= want_reg);
        end
        else
        begin
            // a target below the header size wraps negative and never matches
            match = cmp_valid_reg && ({1'b0, ram_rdata.start} == target_reg);
        end
        exhausted = !cmp_valid_reg && (rd_idx_reg >= count_reg);
        used_sum  = (ADDR_W+2)'(used_reg) + (ADDR_W+2)'(need_reg);
        top_sum   = (ADDR_W+2)'(heap_top_reg) + (ADDR_W+2)'(need_reg);

        sts.done     = !first_reg && (ignored_reg || found_reg || exhausted);
        sts.out_busy = rsp_valid_reg && rsp_stall;
    end

    // outcome of the request once the walk is over
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = found_idx_reg;
        wr_ent     = found_ent_reg;
        append     = 1'b0;
        res.status = ST_OK;
        res.addr   = '0;
        priority if (ignored_reg)
        begin
            res.status = ST_IGNORED;
        end
        else if (found_reg)
        begin
            if (mode_reg == MODE_ALLOC)
            begin
                wr_en       = 1'b1;
                wr_ent.free = 1'b0;
                res.addr    = found_ent_reg.start + HDR;
            end
            else if (found_ent_reg.free)
            begin
                res.status = ST_DOUBLE_FREE;
            end
            else
            begin
                wr_en       = 1'b1;
                wr_ent.free = 1'b1;
            end
        end
        else if (mode_reg == MODE_ALLOC)
        begin
            if (grow_ok_reg)
            begin
                wr_en        = 1'b1;
                append       = 1'b1;
                wr_addr      = count_reg[AW-1:0];
                wr_ent.free  = 1'b0;
                wr_ent.size  = want_reg;
                wr_ent.start = heap_top_reg;
                res.addr     = heap_top_reg + HDR;
            end
            else
            begin
                res.status = ST_NO_SPACE;
            end
        end
        else
        begin
            res.status = ST_UNKNOWN;
        end
        wr_en  = wr_en && cmd.commit;
        append = append && cmd.commit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= req.mode;
            want_reg    <= req.req_size;
            target_reg  <= (ADDR_W+1)'(req.free_addr) - (ADDR_W+1)'(HDR);
            need_reg    <= (ADDR_W+1)'(req.req_size) + (ADDR_W+1)'(HDR);
            ignored_reg <= (req.mode == MODE_ALLOC) ? (req.req_size == '0)
                                                    : (req.free_addr == '0);
        end
        if (cmd.step)
        begin
            cmp_idx_reg <= rd_idx_reg[AW-1:0];
            if (match && !found_reg)
            begin
                found_idx_reg <= cmp_idx_reg;
                found_ent_reg <= ram_rdata;
            end
        end
        if (cmd.commit)
        begin
            rsp_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= ADDR_MAX;
            heap_top_reg  <= BASE;
            used_reg      <= '0;
            count_reg     <= '0;
            grow_ok_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            grow_ok_reg <= (used_sum <= (ADDR_W+2)'(limit_reg))
                        && (top_sum <= (ADDR_W+2)'(ADDR_MAX))
                        && (count_reg < COUNT_MAX);
            first_reg <= cmd.load;
            if (cmd.load)
            begin
                rd_idx_reg    <= '0;
                cmp_valid_reg <= 1'b0;
                found_reg     <= 1'b0;
            end
            else if (cmd.step)
            begin
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                cmp_valid_reg <= (rd_idx_reg < count_reg);
                if (match)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (append)
            begin
                count_reg    <= count_reg + 1'b1;
                heap_top_reg <= top_sum[ADDR_W-1:0];
                used_reg     <= used_sum[ADDR_W-1:0];
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("block count above table depth");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status != ST_OK) |-> rsp_reg.addr == '0)
        else $error("nonzero address on a failed request");

    a_heap_track: assert property (@(posedge clk) disable iff (!rst_n)
        heap_top_reg == used_reg + BASE)
        else $error("heap top and used bytes disagree");

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(rsp_valid_reg && rsp_stall))
        else $error("result overwrites a stalled beat");

    a_append_once: assert property (@(posedge clk) disable iff (!rst_n)
        append |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not grow the table");

endmodule

`default_nettype wire

/* hdl/first_fit_block_allocator.sv */
// top level of the first-fit block allocator: controller plus datapath
// depends on ffba_pkg, ffba_ctrl, ffba_dp (and ffba_ram below it)
//
// usage:
//   request channel req_valid/req_stall/req carries one beat per request:
//   mode 0 allocates req_size payload bytes, mode 1 frees payload address
//   free_addr. each request gives exactly one beat on rsp_valid/rsp_stall/rsp
//   with a status code and, for a successful allocate, the payload address.
//   the heap limit is to be written through cfg_we/cfg_wdata by the user only
//   while the block is idle; the block itself does not enforce this. the table
//   lives in one ram with a single read port and is walked one entry per cycle
//   from entry 0; the walk stops at the first fitting or matching block or at
//   the end of the table (count blocks, at most MAX_BLOCKS); a zero size or
//   null request is answered without a search. the next request can be taken
//   in the cycle after the result is written into the output register.
//   one request is in work at a time; req_stall is high from accept until the
//   result is written into the output register.
//   a new request is taken while a result still waits in the output register;
//   when rsp_stall holds a result, the next one waits inside the block.
//   reset empties the table, sets the heap top to HEAP_BASE and the limit to
//   its full value; the table ram itself is not cleared.
`default_nettype none

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24,
    parameter int HEAP_BASE    = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire ffba_pkg::req_t              req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output ffba_pkg::rsp_t                   rsp,
    input  wire logic                        cfg_we,
    input  wire logic [ffba_pkg::ADDR_W-1:0] cfg_wdata
);
    import ffba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ffba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ffba_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .HEAP_BASE    (HEAP_BASE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_first_fit_block_allocator.sv */
// self-checking testbench for first_fit_block_allocator: directed table then random
// allocate/free traffic, every result checked against a typed row or the heap table model
// depends on ffba_pkg and the allocator rtl
module tb_first_fit_block_allocator;

    import ffba_pkg::*;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int HEAP_BASE    = 16;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DIR_ROWS     = 21;

    typedef enum logic [2:0] {
        ROW_FIXED,
        ROW_FIT_LIMIT,
        ROW_OVER_LIMIT,
        ROW_OVER_TOP,
        ROW_SET_LIMIT
    } row_kind_e;

    // value is the free address, or the limit for ROW_SET_LIMIT
    typedef struct packed {
        row_kind_e           kind;
        logic                mode;
        logic [ADDR_W-1:0]   size;
        logic [ADDR_W-1:0]   value;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    req_t                req = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    rsp_t                rsp;
    logic                cfg_we = 1'b0;
    logic [ADDR_W-1:0]   cfg_wdata = '0;

    // heap table as the block should hold it
    logic [ADDR_W-1:0]   tbl_start [MAX_BLOCKS];
    logic [ADDR_W-1:0]   tbl_size [MAX_BLOCKS];
    bit                  tbl_free [MAX_BLOCKS];
    int                  tbl_count = 0;
    logic [ADDR_W-1:0]   heap_top = ADDR_W'(HEAP_BASE);
    logic [ADDR_W-1:0]   heap_limit = ADDR_MAX;

    rsp_t                heap_replies [$];
    int                  err_count = 0;
    int                  cycles = 0;
    bit                  gaps_on = 1'b1;
    bit                  hold_rsp_long = 1'b0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_FIXED, MODE_ALLOC, 24'd0, 24'd0, 1'b1, ST_IGNORED, 24'd0},
        '{ROW_FIXED, MODE_FREE, ADDR_MAX, 24'd0, 1'b1, ST_IGNORED, 24'd0},
        '{ROW_FIXED, MODE_FREE, 24'd0, ADDR_MAX, 1'b1, ST_UNKNOWN, 24'd0},
        '{ROW_FIXED, MODE_ALLOC, 24'd1, ADDR_MAX, 1'b1, ST_OK, 24'd40},
        '{ROW_FIXED, MODE_FREE, 24'd0, 24'd40, 1'b1, ST_OK, 24'd0},
        '{ROW_FIXED, MODE_FREE, 24'd0, 24'd40, 1'b1, ST_DOUBLE_FREE, 24'd0},
        '{ROW_FIXED, MODE_ALLOC, 24'd1, 24'd0, 1'b1, ST_OK, 24'd40},
        '{ROW_FIXED, MODE_ALLOC, ADDR_MAX, 24'd0, 1'b1, ST_NO_SPACE, 24'd0},
        '{ROW_FIXED, MODE_FREE, 24'd0, 24'd41, 1'b1, ST_UNKNOWN, 24'd0},
        '{ROW_FIXED, MODE_FREE, 24'd0, 24'd16, 1'b1, ST_UNKNOWN, 24'd0},
        '{ROW_FIXED, MODE_ALLOC, 24'd100, 24'd0, 1'b0, ST_OK, 24'd0},
        '{ROW_OVER_TOP, MODE_ALLOC, 24'd0, 24'd0, 1'b0, ST_OK, 24'd0},
        '{ROW_SET_LIMIT, MODE_ALLOC, 24'd0, 24'd0, 1'b0, ST_OK, 24'd0},
        '{ROW_FIXED, MODE_ALLOC, 24'd5, 24'd0, 1'b1, ST_NO_SPACE, 24'd0},
        '{ROW_FIXED, MODE_FREE, 24'd0, 24'd65, 1'b1, ST_OK, 24'd0},
        '{ROW_FIXED, MODE_ALLOC, 24'd50, 24'd0, 1'b1, ST_OK, 24'd65},
        '{ROW_SET_LIMIT, MODE_ALLOC, 24'd0, 24'd1000, 1'b0, ST_OK, 24'd0},
        '{ROW_FIT_LIMIT, MODE_ALLOC, 24'd0, 24'd0, 1'b0, ST_OK, 24'd0},
        '{ROW_FIXED, MODE_ALLOC, 24'd1, 24'd0, 1'b1, ST_NO_SPACE, 24'd0},
        '{ROW_SET_LIMIT, MODE_ALLOC, 24'd0, 24'd2000, 1'b0, ST_OK, 24'd0},
        '{ROW_OVER_LIMIT, MODE_ALLOC, 24'd0, 24'd0, 1'b0, ST_OK, 24'd0}
    };

    first_fit_block_allocator #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .HEAP_BASE    (HEAP_BASE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // first-fit search, append at heap top, or free by payload address
    function automatic rsp_t allocate_or_free(req_t r);
        rsp_t   o;
        int     i;
        bit     found;
        longint need;
        longint used;
        o = '0;
        o.status = ST_OK;
        found = 1'b0;
        if (r.mode == MODE_ALLOC)
        begin
            if (r.req_size == 0)
                o.status = ST_IGNORED;
            else
            begin
                for (i = 0; i < tbl_count && !found; i++)
                begin
                    if (tbl_free[i] && tbl_size[i] >= r.req_size)
                    begin
                        tbl_free[i] = 1'b0;
                        o.addr = tbl_start[i] + ADDR_W'(HEADER_BYTES);
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    need = longint'(HEADER_BYTES) + longint'(r.req_size);
                    used = longint'(heap_top) - HEAP_BASE;
                    if (tbl_count >= MAX_BLOCKS || used + need > longint'(heap_limit)
                        || longint'(heap_top) + need > longint'(ADDR_MAX))
                        o.status = ST_NO_SPACE;
                    else
                    begin
                        tbl_start[tbl_count] = heap_top;
                        tbl_size[tbl_count] = r.req_size;
                        tbl_free[tbl_count] = 1'b0;
                        tbl_count++;
                        o.addr = heap_top + ADDR_W'(HEADER_BYTES);
                        heap_top = heap_top + need[ADDR_W-1:0];
                    end
                end
            end
        end
        else
        begin
            if (r.free_addr == 0)
                o.status = ST_IGNORED;
            else
            begin
                o.status = ST_UNKNOWN;
                for (i = 0; i < tbl_count && !found; i++)
                begin
                    if (longint'(tbl_start[i]) + HEADER_BYTES == longint'(r.free_addr))
                    begin
                        found = 1'b1;
                        if (tbl_free[i])
                            o.status = ST_DOUBLE_FREE;
                        else
                        begin
                            tbl_free[i] = 1'b1;
                            o.status = ST_OK;
                        end
                    end
                end
            end
        end
        if (o.status != ST_OK)
            o.addr = '0;
        return o;
    endfunction

    // mostly small sizes and frees of payload addresses in the table, some noise
    function automatic req_t pick_request(int alloc_pct);
        req_t r;
        int   k;
        r.mode = MODE_ALLOC;
        r.req_size = ADDR_W'($urandom);
        r.free_addr = ADDR_W'($urandom);
        k = $urandom_range(0, 19);
        if ($urandom_range(0, 99) < alloc_pct)
        begin
            if (k == 0)
                r.req_size = '0;
            else if (k > 2)
                r.req_size = ADDR_W'($urandom_range(1, 300));
        end
        else
        begin
            r.mode = MODE_FREE;
            if (k == 0)
                r.free_addr = '0;
            else if (tbl_count > 0 && k == 3)
                r.free_addr = tbl_start[$urandom_range(0, tbl_count - 1)]
                              + ADDR_W'(HEADER_BYTES) + 1'b1;
            else if (tbl_count > 0 && k > 3)
                r.free_addr = tbl_start[$urandom_range(0, tbl_count - 1)]
                              + ADDR_W'(HEADER_BYTES);
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [ADDR_W-1:0] want_v,
                                 logic [ADDR_W-1:0] got_v);
        err_count++;
        if (err_count <= 10)
            $display("mismatch: %s expected %0d got %0d", what, want_v, got_v);
    endtask

    // called just after a rising edge; returns just after the edge that took the beat
    task automatic offer(req_t r, bit typed, rsp_t typed_rsp);
        rsp_t predicted;
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = allocate_or_free(r);
        heap_replies.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic maybe_pause();
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (heap_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [ADDR_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        heap_limit = v;
    endtask

    task automatic run_random(int n, int alloc_pct);
        repeat (n)
        begin
            offer(pick_request(alloc_pct), 1'b0, '0);
            maybe_pause();
        end
    endtask

    // result side stalls in bursts, plus one long hold that backs up the request side
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_rsp_long)
            begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_stall <= 1'b0;
                hold_rsp_long = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_replies
        rsp_t owed;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (heap_replies.size() == 0)
                flag_mismatch("result with none outstanding, status", '0,
                              ADDR_W'(rsp.status));
            else
            begin
                owed = heap_replies.pop_front();
                if (rsp.status !== owed.status)
                    flag_mismatch("status", ADDR_W'(owed.status), ADDR_W'(rsp.status));
                if (rsp.addr !== owed.addr)
                    flag_mismatch("addr", owed.addr, rsp.addr);
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        req_t             r;
        rsp_t             typed_rsp;
        logic [ADDR_W-1:0] room;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[n])
        begin
            if (dir_rows[n].kind == ROW_SET_LIMIT)
                write_limit(dir_rows[n].value);
            else
            begin
                // sizes exactly at the limit, or one byte over it or over ADDR_MAX
                room = heap_limit - (heap_top - ADDR_W'(HEAP_BASE)) - ADDR_W'(HEADER_BYTES);
                r.mode = dir_rows[n].mode;
                r.free_addr = dir_rows[n].value;
                unique case (dir_rows[n].kind)
                    ROW_FIT_LIMIT:  r.req_size = room;
                    ROW_OVER_LIMIT: r.req_size = room + 1'b1;
                    ROW_OVER_TOP:   r.req_size = ADDR_MAX - heap_top
                                                 - ADDR_W'(HEADER_BYTES) + 1'b1;
                    default:        r.req_size = dir_rows[n].size;
                endcase
                typed_rsp.status = dir_rows[n].status;
                typed_rsp.addr = dir_rows[n].addr;
                offer(r, dir_rows[n].typed, typed_rsp);
                maybe_pause();
            end
        end

        write_limit('0);
        run_random(80, 55);
        write_limit(24'd3000);
        hold_rsp_long = 1'b1;
        run_random(300, 55);
        write_limit(ADDR_W'($urandom_range(3001, 8000)));
        run_random(300, 55);
        // full limit: growth until the table runs out of rows
        write_limit(ADDR_MAX);
        run_random(300, 75);
        gaps_on = 1'b0;
        run_random(320, 60);

        drain();
        repeat (MAX_BLOCKS + 8) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/ffba_ctrl.sv
hdl/ffba_dp.sv
hdl/first_fit_block_allocator.sv
tb/sv/tb_first_fit_block_allocator.sv
